// ----- rtl/ghpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghpf_pkg
// Shared constants, codes and controller/datapath interface types for the
// 5x5 Gaussian high-pass pixel filter.
// ----------------------------------------------------------------------------
package ghpf_pkg;

  localparam int MaxWidth     = 1024;
  localparam int ColW         = $clog2(MaxWidth);          // column index bits
  localparam int WidthW       = ColW + 1;                  // image width bits
  localparam int StoreRows    = 7;
  localparam int RowW         = 3;
  localparam int StoreDepth   = StoreRows * MaxWidth;
  localparam int AddrW        = $clog2(StoreDepth);
  localparam int TapSpan      = 5;
  localparam int TapW         = 3;
  localparam int CoefW        = 17;
  localparam int CoefFracBits = 16;
  localparam int NumCoef      = 6;
  localparam int SelW         = 3;
  localparam int PendW        = WidthW + 1;                // holds up to 2W+3
  localparam int ProdW        = CoefW + 8;
  localparam int AccW         = ProdW + 5;                 // 25 taps
  localparam int BlurW        = AccW - CoefFracBits;
  localparam int DivW         = 22;                        // |t| magnitude bits
  localparam int RecipW       = 23;
  localparam int Recip        = 4210753;                   // ceil(2^30 / 255)
  localparam int RecipShift   = 30;
  localparam int Divisor      = 255;
  localparam int Offset       = 32385;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = CoefW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_COEF_DIST0    = 3'd2,
    CFG_COEF_DIST1    = 3'd3,
    CFG_COEF_DIST2    = 3'd4,
    CFG_COEF_DIST4    = 3'd5,
    CFG_COEF_DIST5    = 3'd6,
    CFG_COEF_DIST8    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic write;
    logic clear;
    logic tap_issue;
    logic div_load;
    logic div_step;
    logic result_put;
  } ghpf_cmd_t;

  typedef struct packed {
    logic draining;
    logic flush;
    logic pend_zero;
    logic pixel_emit;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } ghpf_status_t;

  // Coefficient class of a tap from its window position (0..4 each way).
  function automatic logic [SelW-1:0] coef_sel(input logic [TapW-1:0] ty,
                                               input logic [TapW-1:0] tx);
    logic [1:0] ay;
    logic [1:0] ax;
    logic [SelW-1:0] sel;
    ay = (ty >= 3'd2) ? 2'(ty - 3'd2) : 2'(3'd2 - ty);
    ax = (tx >= 3'd2) ? 2'(tx - 3'd2) : 2'(3'd2 - tx);
    unique case ({ay, ax})
      4'b0000:                   sel = 3'd0;
      4'b0001, 4'b0100:          sel = 3'd1;
      4'b0101:                   sel = 3'd2;
      4'b0010, 4'b1000:          sel = 3'd3;
      4'b0110, 4'b1001:          sel = 3'd4;
      4'b1010:                   sel = 3'd5;
      default:                   sel = 3'd0;
    endcase
    return sel;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gaussian_high_pass_pixel_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An item that yields a result goes through evaluate, tap walk, pipeline tail, divider
// load, divide and put, in that order, before the input is free again; an item without a
// result frees the input once it has been evaluated.
// The block takes a new item only once it is through with the last one, and waits longer
// while the output is stalled; the 25-tap walk over the single-port line store dominates.
// Reset: asynchronous, active low; counters and control clear, registers take their
// defaults, and the line store is left as is (stale entries are masked until written).
// ----------------------------------------------------------------------------
// gaussian_high_pass_pixel_filter_unit
// Streaming 5x5 Gaussian high-pass filter with grey conversion and line store.
// ----------------------------------------------------------------------------
module gaussian_high_pass_pixel_filter_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [ghpf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [ghpf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [31:0]                    s_axis_tdata,  // channel_0..channel_3
  input  wire                            s_axis_tuser,  // is_flush
  input  wire                            s_axis_tlast,  // end_of_frame
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // filtered_pixel
  output logic                           m_axis_tlast   // last_of_frame
);
  import ghpf_pkg::*;

  ghpf_cmd_t    cmd;
  ghpf_status_t status;

  ghpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ghpf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_flush_i  (s_axis_tuser),
    .in_eof_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/ghpf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghpf_ctrl
// Sequencer: accepts one item, updates the line store and, for a result, walks
// the 25 window taps, runs the divider and hands it to the output register.
// ----------------------------------------------------------------------------
module ghpf_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  ghpf_pkg::ghpf_status_t status_i,
  output ghpf_pkg::ghpf_cmd_t    cmd_o
);
  import ghpf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EVAL  = 7'b0000010,
    ST_TAP   = 7'b0000100,
    ST_TAIL  = 7'b0001000,
    ST_DIVLD = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_PUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.draining) begin
          if (status_i.pend_zero) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_TAP;
          end
        end else if (status_i.flush) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.write = 1'b1;
          state_d     = status_i.pixel_emit ? ST_TAP : ST_IDLE;
        end
      end
      ST_TAP: begin
        cmd_o.tap_issue = 1'b1;
        if (status_i.tap_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (!status_i.pipe_busy) state_d = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_PUT;
      end
      ST_PUT: begin
        if (status_i.out_free) begin
          cmd_o.result_put = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The divider must never be loaded while products are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVLD) |-> !status_i.pipe_busy)
    else $error("divider loaded while tap pipeline busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EVAL))
    else $error("accepted item not evaluated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.write || cmd_o.clear) |-> (state_q == ST_EVAL))
    else $error("store update outside evaluation");

endmodule
`default_nettype wire

// ----- rtl/ghpf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghpf_datapath
// Configuration registers, grey conversion, line store, position counters,
// tap multiply-accumulate, divide-by-255 unit and the output register.
// ----------------------------------------------------------------------------
module ghpf_datapath (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [ghpf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [ghpf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire  [31:0]                      in_data_i,
  input  wire                              in_flush_i,
  input  wire                              in_eof_i,
  input  ghpf_pkg::ghpf_cmd_t               cmd_i,
  output ghpf_pkg::ghpf_status_t            status_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [7:0]                       out_pixel_o,
  output logic                             out_last_o
);
  import ghpf_pkg::*;

  // Configuration.
  logic [WidthW-1:0] cfg_width_q;
  logic [2:0]        cfg_cc_q;
  logic [CoefW-1:0]  coef_q [NumCoef];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= WidthW'(640);
      cfg_cc_q    <= 3'd3;
      coef_q[0]   <= CoefW'(65536);
      coef_q[1]   <= '0;
      coef_q[2]   <= '0;
      coef_q[3]   <= '0;
      coef_q[4]   <= '0;
      coef_q[5]   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:   cfg_width_q <= cfg_data_i[WidthW-1:0];
        CFG_CHANNEL_COUNT: cfg_cc_q    <= cfg_data_i[2:0];
        CFG_COEF_DIST0:    coef_q[0]   <= cfg_data_i;
        CFG_COEF_DIST1:    coef_q[1]   <= cfg_data_i;
        CFG_COEF_DIST2:    coef_q[2]   <= cfg_data_i;
        CFG_COEF_DIST4:    coef_q[3]   <= cfg_data_i;
        CFG_COEF_DIST5:    coef_q[4]   <= cfg_data_i;
        CFG_COEF_DIST8:    coef_q[5]   <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // Accepted item.
  logic [9:0] sum_q;
  logic [2:0] cc_q;
  logic       flush_q;
  logic       eof_q;
  logic [2:0] cc_eff;
  logic [9:0] sum_d;

  always_comb begin
    if (cfg_cc_q == 3'd0)     cc_eff = 3'd1;
    else if (cfg_cc_q > 3'd4) cc_eff = 3'd4;
    else                      cc_eff = cfg_cc_q;
    unique case (cc_eff)
      3'd1:    sum_d = {2'b0, in_data_i[7:0]};
      3'd2:    sum_d = 10'(in_data_i[7:0]) + 10'(in_data_i[15:8]);
      3'd3:    sum_d = 10'(in_data_i[7:0]) + 10'(in_data_i[15:8])
                       + 10'(in_data_i[23:16]);
      default: sum_d = 10'(in_data_i[7:0]) + 10'(in_data_i[15:8])
                       + 10'(in_data_i[23:16]) + 10'(in_data_i[31:24]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sum_q   <= sum_d;
      cc_q    <= cc_eff;
      flush_q <= in_flush_i;
      eof_q   <= in_eof_i;
    end
  end

  // Divide by three through the reciprocal 683/2048, exact for sums up to 1020.
  logic [19:0] third;
  logic [7:0]  grey;
  assign third = 20'(sum_q) * 20'd683;
  always_comb begin
    unique case (cc_q)
      3'd1:    grey = sum_q[7:0];
      3'd2:    grey = sum_q[8:1];
      3'd3:    grey = third[18:11];
      default: grey = sum_q[9:2];
    endcase
  end

  // Position counters. pend_q counts items written but not yet output.
  logic [ColW-1:0]   in_col_q, out_col_q;
  logic [RowW-1:0]   in_row_q, out_row_q;
  logic              in_row_any_q;
  logic [1:0]        out_rows_q;
  logic [PendW-1:0]  pend_q;
  logic [WidthW-1:0] frame_w_q;
  logic              draining_q;
  logic              in_at_start;
  logic [WidthW-1:0] w_clamp, w_eff;
  logic              last_now;

  assign in_at_start = (in_col_q == '0) && !in_row_any_q;
  always_comb begin
    if (cfg_width_q == '0)                      w_clamp = WidthW'(1);
    else if (cfg_width_q > WidthW'(MaxWidth))   w_clamp = WidthW'(MaxWidth);
    else                                        w_clamp = cfg_width_q;
    w_eff = in_at_start ? w_clamp : frame_w_q;
  end

  assign last_now = draining_q && (pend_q == PendW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_row_any_q <= 1'b0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_rows_q   <= '0;
      pend_q       <= '0;
      frame_w_q    <= WidthW'(640);
      draining_q   <= 1'b0;
    end else if (cmd_i.clear || (cmd_i.result_put && last_now)) begin
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_row_any_q <= 1'b0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_rows_q   <= '0;
      pend_q       <= '0;
      draining_q   <= 1'b0;
    end else if (cmd_i.write) begin
      frame_w_q <= w_eff;
      pend_q    <= pend_q + PendW'(1);
      if (eof_q) draining_q <= 1'b1;
      if (WidthW'(in_col_q) + WidthW'(1) == w_eff) begin
        in_col_q     <= '0;
        in_row_q     <= (in_row_q == RowW'(StoreRows - 1)) ? '0 : in_row_q + RowW'(1);
        in_row_any_q <= 1'b1;
      end else begin
        in_col_q <= in_col_q + ColW'(1);
      end
    end else if (cmd_i.result_put) begin
      pend_q <= pend_q - PendW'(1);
      if (WidthW'(out_col_q) + WidthW'(1) == frame_w_q) begin
        out_col_q <= '0;
        out_row_q <= (out_row_q == RowW'(StoreRows - 1)) ? '0 : out_row_q + RowW'(1);
        if (out_rows_q != 2'd2) out_rows_q <= out_rows_q + 2'd1;
      end else begin
        out_col_q <= out_col_q + ColW'(1);
      end
    end
  end

  // Line store.
  logic [7:0]       store_mem [StoreDepth];
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       rd_data_q;

  assign wr_addr = AddrW'(in_row_q) * AddrW'(MaxWidth) + AddrW'(in_col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) store_mem[wr_addr] <= grey;
  end

  // Tap walk: ty is the window row (0 is two rows above), tx the column.
  logic [TapW-1:0] ty_q, tx_q;
  logic            tap_last;
  logic [3:0]      row_sum;
  logic [RowW-1:0] tap_row;
  logic [ColW+1:0] col_sum;
  logic [ColW-1:0] tap_col;
  logic            row_ok, col_ok, rast_ok;
  logic [PendW+1:0] pend_ext;

  assign tap_last = (ty_q == TapW'(TapSpan - 1)) && (tx_q == TapW'(TapSpan - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ty_q <= '0;
      tx_q <= '0;
    end else if (cmd_i.tap_issue) begin
      if (tx_q == TapW'(TapSpan - 1)) begin
        tx_q <= '0;
        ty_q <= tap_last ? '0 : ty_q + TapW'(1);
      end else begin
        tx_q <= tx_q + TapW'(1);
      end
    end
  end

  always_comb begin
    // Row (out_row + ty - 2) modulo the store height; -2 is +5 modulo 7.
    row_sum = 4'(out_row_q) + 4'(ty_q) + 4'd5;
    if (row_sum >= 4'd14)     tap_row = RowW'(row_sum - 4'd14);
    else if (row_sum >= 4'd7) tap_row = RowW'(row_sum - 4'd7);
    else                      tap_row = RowW'(row_sum);
    col_sum = (ColW+2)'(out_col_q) + (ColW+2)'(tx_q);
    tap_col = ColW'(col_sum - (ColW+2)'(2));
    col_ok  = (col_sum >= (ColW+2)'(2)) &&
              (col_sum < (ColW+2)'(frame_w_q) + (ColW+2)'(2));
    unique case (ty_q)
      3'd0:    row_ok = (out_rows_q == 2'd2);
      3'd1:    row_ok = (out_rows_q != 2'd0);
      default: row_ok = 1'b1;
    endcase
    // A tap in or below the center row must already have been written.
    pend_ext = (PendW+2)'(pend_q) + (PendW+2)'(2);
    unique case (ty_q)
      3'd2:    rast_ok = (PendW+2)'(tx_q) < pend_ext;
      3'd3:    rast_ok = (PendW+2)'(frame_w_q) + (PendW+2)'(tx_q) < pend_ext;
      3'd4:    rast_ok = ((PendW+2)'(frame_w_q) << 1) + (PendW+2)'(tx_q) < pend_ext;
      default: rast_ok = 1'b1;
    endcase
  end

  assign rd_addr = AddrW'(tap_row) * AddrW'(MaxWidth) + AddrW'(tap_col);

  // Stage 1: store read, tap qualification and coefficient class.
  logic            rd_vld_q, tap_ok_q, center_q1;
  logic [SelW-1:0] sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_issue) rd_data_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.tap_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_issue) begin
      tap_ok_q  <= row_ok && col_ok && rast_ok;
      sel_q     <= coef_sel(ty_q, tx_q);
      center_q1 <= (ty_q == TapW'(2)) && (tx_q == TapW'(2));
    end
  end

  // Stage 2: product. Stage 3: accumulate.
  logic [7:0]       tap_val;
  logic [ProdW-1:0] prod_q;
  logic             prod_vld_q;
  logic [7:0]       center_q;
  logic [AccW-1:0]  acc_q;

  assign tap_val = tap_ok_q ? rd_data_q : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= ProdW'(tap_val) * ProdW'(coef_q[sel_q]);
      if (center_q1) center_q <= tap_val;
    end
    if (cmd_i.accept)    acc_q <= '0;
    else if (prod_vld_q) acc_q <= acc_q + AccW'(prod_q);
  end

  // Signed t = (grey - blur) * 128 + 32385, then |t| / 255 by a multiply with
  // ceil(2^30 / 255) and a shift, which is exact for every |t| below 2^22.
  logic [BlurW-1:0]       blur;
  logic [DivW:0]          t_val;
  logic [DivW-1:0]        div_m_q;
  logic [7:0]             div_quo_q;
  logic                   div_neg_q;
  logic [DivW+RecipW-1:0] div_prod;

  assign blur  = acc_q[AccW-1:CoefFracBits];
  assign t_val = ((DivW+1)'(center_q) << 7) - ((DivW+1)'(blur) << 7)
                 + (DivW+1)'(Offset);
  assign div_prod = (DivW+RecipW)'(div_m_q) * (DivW+RecipW)'(Recip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_neg_q <= t_val[DivW];
      div_m_q   <= t_val[DivW] ? DivW'(-t_val) : t_val[DivW-1:0];
    end
    if (cmd_i.div_step) begin
      div_quo_q <= div_prod[RecipShift +: 8];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.result_put) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_put) begin
      out_pixel_o <= div_neg_q ? 8'(-div_quo_q) : div_quo_q;
      out_last_o  <= last_now;
    end
  end

  always_comb begin
    status_o.draining   = draining_q;
    status_o.flush      = flush_q;
    status_o.pend_zero  = (pend_q == '0);
    status_o.pixel_emit = ((PendW+1)'(pend_q) + (PendW+1)'(1)) >
                          (((PendW+1)'(w_eff) << 1) + (PendW+1)'(2));
    status_o.tap_last   = tap_last;
    status_o.pipe_busy  = rd_vld_q || prod_vld_q;
    status_o.out_free   = !out_valid_o || out_ready_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PendW+1)'(pend_q) <= ((PendW+1)'(frame_w_q) << 1) + (PendW+1)'(3))
    else $error("pending count beyond window lag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WidthW'(in_col_q) < frame_w_q) && (WidthW'(out_col_q) < frame_w_q))
    else $error("column counter beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_put |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote an untaken transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_put |-> (pend_q != '0))
    else $error("result with nothing pending");

endmodule
`default_nettype wire

// ----- sim/ghpf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghpf_checker
// Watches the configuration port and both streams of the Gaussian high-pass
// filter, predicts each filtered pixel and compares it with the output.
// ----------------------------------------------------------------------------
module ghpf_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [ghpf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [ghpf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  input  wire  [31:0]                    s_axis_tdata,
  input  wire                            s_axis_tuser,
  input  wire                            s_axis_tlast,
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  input  wire  [7:0]                     m_axis_tdata,
  input  wire                            m_axis_tlast,
  output int                             fail_count,
  output int                             pixels_pending,
  output int                             pixels_checked
);
  import ghpf_pkg::*;

  typedef struct packed {
    logic [7:0] filtered;
    logic       last;
  } out_pixel_t;

  out_pixel_t  expected_q[$];
  logic [7:0]  grey_rows [StoreRows*MaxWidth];
  logic [7:0]  window [TapSpan][TapSpan];
  int          in_col, in_row, out_col, out_row, frame_w;
  bit          draining;
  logic [10:0] width_reg;
  logic [2:0]  chan_reg;
  logic [16:0] coef [NumCoef];

  assign pixels_pending = expected_q.size();

  initial begin
    fail_count     = 0;
    pixels_checked = 0;
  end

  function automatic longint tap_weight(int d2);
    case (d2)
      0: return coef[0];
      1: return coef[1];
      2: return coef[2];
      4: return coef[3];
      5: return coef[4];
      8: return coef[5];
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Filter the pixel at the current output position and advance it.
  task automatic filter_next_pixel();
    longint written, k, acc, blur, t, q;
    int tr, tc;
    logic [7:0] v;
    out_pixel_t px;
    written = longint'(in_row) * frame_w + in_col;
    k = longint'(out_row) * frame_w + out_col;
    if (k >= written) begin
      draining = 0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      return;
    end
    acc = 0;
    for (int dy = -2; dy <= 2; dy++) begin
      for (int dx = -2; dx <= 2; dx++) begin
        tr = out_row + dy;
        tc = out_col + dx;
        v = 8'd0;
        if (tr >= 0 && tc >= 0 && tc < frame_w && longint'(tr) * frame_w + tc < written)
          v = grey_rows[(tr % StoreRows) * MaxWidth + tc];
        window[dy+2][dx+2] = v;
        acc += tap_weight(dy*dy + dx*dx) * v;
      end
    end
    blur = acc >>> CoefFracBits;
    t = (longint'(window[2][2]) - blur) * 128 + Offset;
    q = t / Divisor;  // truncates toward zero
    px.filtered = q[7:0];
    px.last = 1'b0;
    out_col++;
    if (out_col >= frame_w) begin
      out_col = 0;
      out_row++;
    end
    if (draining && k + 1 == written) begin
      px.last = 1'b1;
      draining = 0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    expected_q.push_back(px);
  endtask

  task automatic accept_item();
    int cc, sum;
    longint written, k;
    if (draining) begin
      filter_next_pixel();
      return;
    end
    if (s_axis_tuser) return;
    if (in_row == 0 && in_col == 0)
      frame_w = (width_reg == 0) ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    cc = (chan_reg == 0) ? 1 : (chan_reg > 4 ? 4 : chan_reg);
    sum = 0;
    for (int i = 0; i < cc; i++) sum += s_axis_tdata[8*i +: 8];
    grey_rows[(in_row % StoreRows) * MaxWidth + in_col] = 8'(sum / cc);
    in_col++;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row++;
    end
    if (s_axis_tlast) draining = 1;
    written = longint'(in_row) * frame_w + in_col;
    k = longint'(out_row) * frame_w + out_col;
    if (k + 2 * frame_w + 2 < written) filter_next_pixel();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_w = 640;
      draining = 0;
      width_reg = 11'd640;
      chan_reg = 3'd3;
      coef[0] = 17'd65536;
      for (int i = 1; i < NumCoef; i++) coef[i] = 17'd0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected filtered_pixel", m_axis_tdata, -1);
        end else begin
          if (m_axis_tdata !== expected_q[0].filtered)
            report_mismatch("filtered_pixel", m_axis_tdata, expected_q[0].filtered);
          if (m_axis_tlast !== expected_q[0].last)
            report_mismatch("last_of_frame", m_axis_tlast, expected_q[0].last);
          void'(expected_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:   width_reg = cfg_data_i[10:0];
          CFG_CHANNEL_COUNT: chan_reg = cfg_data_i[2:0];
          CFG_COEF_DIST0:    coef[0] = cfg_data_i;
          CFG_COEF_DIST1:    coef[1] = cfg_data_i;
          CFG_COEF_DIST2:    coef[2] = cfg_data_i;
          CFG_COEF_DIST4:    coef[3] = cfg_data_i;
          CFG_COEF_DIST5:    coef[4] = cfg_data_i;
          CFG_COEF_DIST8:    coef[5] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) accept_item();
    end
  end

endmodule

// ----- sim/tb_gaussian_high_pass_pixel_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_high_pass_pixel_filter_unit
// Drives frames of pixels, drain items and stray flushes through the filter
// under several widths, channel counts and kernels, with random idling on
// both streams; the checker predicts and compares every output pixel.
// ----------------------------------------------------------------------------
module tb_gaussian_high_pass_pixel_filter_unit;
  import ghpf_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;

  int fail_count, pixels_pending, pixels_checked;
  int item_count = 0, frame_count = 0, cfg_count = 0, idle_cycles = 0;
  int width_now = 640;
  bit quiet = 0, hold_req = 0, hold_done = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  gaussian_high_pass_pixel_filter_unit i_dut (.*);

  ghpf_checker i_checker (.*);

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] data, input bit flush, input bit eof,
                           input bit counts);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= flush;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counts) item_count++;
  endtask

  // Waits out outstanding pixels and the block's own latency before a write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_count++;
    if (idx == CFG_IMAGE_WIDTH) width_now = value[10:0];
  endtask

  task automatic configure(input int width, input int chans, input int c0, input int c1,
                           input int c2, input int c4, input int c5, input int c8);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, width);
    write_reg(CFG_CHANNEL_COUNT, chans);
    write_reg(CFG_COEF_DIST0, c0);
    write_reg(CFG_COEF_DIST1, c1);
    write_reg(CFG_COEF_DIST2, c2);
    write_reg(CFG_COEF_DIST4, c4);
    write_reg(CFG_COEF_DIST5, c5);
    write_reg(CFG_COEF_DIST8, c8);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One frame of n pixels followed by its drain; noisy frames add stray
  // flushes, flush with end of frame, and real pixels inside the drain.
  task automatic send_frame(input int n, input bit noisy);
    int wc, drain;
    wc = (width_now == 0) ? 1 : (width_now > MaxWidth ? MaxWidth : width_now);
    drain = (n < 2 * wc + 2) ? n : 2 * wc + 2;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item($urandom, 1'b1, $urandom_range(0, 1), 1'b0);
      send_item(rand_pixel(), 1'b0, i == n - 1, 1'b1);
    end
    for (int i = 0; i < drain; i++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        send_item($urandom, 1'b0, $urandom_range(0, 1), 1'b1);
      else
        send_item($urandom, 1'b1, $urandom_range(0, 1), 1'b1);
    end
    if (noisy && $urandom_range(0, 2) == 0)
      send_item($urandom, 1'b1, 1'b0, 1'b0);
    frame_count++;
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(0, 131071);
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  initial begin
    int n, w;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray flushes at idle, extreme bytes, identity kernel.
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 1'b1, 1'b1, 1'b0);
    configure(3, 4, 65536, 0, 0, 0, 0, 0);
    send_frame(6, 1'b0);
    // Saturating kernel drives the difference negative.
    configure(1, 0, 131071, 131071, 131071, 131071, 131071, 131071);
    send_frame(3, 1'b0);
    configure(0, 7, 0, 65536, 0, 65536, 0, 65536);
    send_frame(2, 1'b0);
    configure(2047, 1, 4096, 8192, 2048, 1024, 512, 256);
    send_frame(2, 1'b0);
    configure(1024, 2, 0, 0, 0, 0, 0, 0);
    send_frame(3, 1'b0);

    while (item_count < 450) begin
      if (item_count > 390) quiet = 1;
      if ($urandom_range(0, 2) == 0 || frame_count < 7) begin
        case ($urandom_range(0, 9))
          0: w = 1024;
          1: w = 0;
          2: w = $urandom_range(1025, 2047);
          default: w = $urandom_range(1, 10);
        endcase
        configure(w, $urandom_range(0, 7), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef(), rand_coef());
      end
      n = (width_now >= 1 && width_now <= 10) ? $urandom_range(1, 30)
                                              : $urandom_range(1, 5);
      if (!hold_req && item_count > 150 && width_now <= 10 && width_now >= 1) begin
        hold_req = 1;
        n = 30;
      end
      send_frame(n, $urandom_range(0, 3) != 0);
      // Now and then pause the sender until every pixel of the frame has come out.
      if ($urandom_range(0, 4) == 0) wait_idle();
    end

    s_axis_tvalid <= 1'b0;
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items in %0d frames over %0d register writes;", item_count,
             frame_count, cfg_count);
    $display("checked %0d output pixels, %0d failures.", pixels_checked, fail_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
